// ----- sv/sdh_pkg.sv -----
// package: types, codes and constants for the sd card spi block host
`timescale 1ns / 1ps
package sdh_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int BUF_AW = $clog2(BLOCK_BYTES);

  localparam logic [7:0] CMD0_C = 8'h40;
  localparam logic [7:0] CMD1_C = 8'h41;
  localparam logic [7:0] CMD17_C = 8'h51;
  localparam logic [7:0] CMD24_C = 8'h58;
  localparam logic [7:0] CRC0_C = 8'h95;
  localparam logic [7:0] TOKEN_C = 8'hfe;
  localparam logic [7:0] FILL_C = 8'hff;
  localparam logic [9:0] PREAMBLE_CLKS = 10'd80;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0, OP_OPEN = 3'd1, OP_FETCH = 3'd2, OP_STORE = 3'd3,
    OP_FLUSH = 3'd4, OP_BUF_WR = 3'd5, OP_BUF_RD = 3'd6, OP_NONE = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_RESET_NOT_IDLE = 3'd1, ST_INIT_NO_ANSWER = 3'd2,
    ST_INIT_TIMEOUT = 3'd3, ST_REJECTED = 3'd4, ST_TOKEN_TIMEOUT = 3'd5,
    ST_RESP_TIMEOUT = 3'd6, ST_BUSY_TIMEOUT = 3'd7
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_PREAMBLE, PH_CMD, PH_RWAIT, PH_RBITS, PH_TOKWAIT,
    PH_RDATA, PH_WDATA, PH_DRWAIT, PH_DRBITS, PH_NBWAIT
  } phase_e;

  localparam logic [0:0] CFG_BUSY_POLL = 1'b0;
  localparam logic [0:0] CFG_INIT_RETRY = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] block_address;
    logic [8:0]  buffer_index;
    logic [7:0]  buffer_data;
    logic        miso;
  } sdh_in_t;

  typedef struct packed {
    logic        chip_select_level;
    logic        mosi_level;
    logic        clock_pulse;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [3:0]  write_response;
    logic [7:0]  read_data;
    logic [15:0] crc_value;
  } sdh_out_t;

  // buffer port requests from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [BUF_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [BUF_AW-1:0] rd_addr;
    logic [BUF_AW-1:0] st_addr;
  } sdh_buf_req_t;

endpackage

// ----- sv/sdh_buffer.sv -----
// block buffer memory, one write and two registered read ports
`timescale 1ns / 1ps
module sdh_buffer import sdh_pkg::*; (
  input  logic         clk_i,
  input  sdh_buf_req_t req_i,
  output logic [7:0]   rd_data_o,
  output logic [7:0]   st_data_o
);

  logic [7:0] mem_q [BLOCK_BYTES];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_o <= mem_q[req_i.rd_addr];
    st_data_o <= mem_q[req_i.st_addr];
  end

endmodule

// ----- sv/sdh_seq.sv -----
// protocol sequencer: phase machine, counters and result register
`timescale 1ns / 1ps
module sdh_seq import sdh_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         step_i,
  input  sdh_in_t      in_i,
  input  logic         adv_i,
  input  logic [7:0]   buf_rd_i,
  output sdh_buf_req_t buf_req_o,
  output logic [7:0]   store_byte_o,
  output sdh_out_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [9:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] poll_q, poll_d, retry_q, retry_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d;
  logic [15:0] crc_q, crc_d, cur_blk_d;
  logic [31:0] cur_q;
  logic [31:0] cur_d;
  logic [2:0]  stat_q, stat_d;
  logic [15:0] poll_lim_q, retry_lim_q, poll_lim, retry_lim, poll_inc, retry_inc;
  logic        poll_fail, done, cs, mosi, clk_p;
  logic [3:0]  wr;
  logic [47:0] frame;
  logic [7:0]  rc, sb;
  sdh_out_t    res_d;

  assign poll_lim = (poll_lim_q == '0) ? 16'd1 : poll_lim_q;
  assign retry_lim = (retry_lim_q == '0) ? 16'd1 : retry_lim_q;
  assign poll_inc = poll_q + 16'd1;
  assign retry_inc = retry_q + 16'd1;
  assign poll_fail = (poll_inc == '0) || (poll_inc >= poll_lim);
  assign frame = {cmd_q, arg_q, (cmd_q == CMD0_C) ? CRC0_C : 8'h00};
  assign cur_blk_d = crc_q;

  // store stream byte
  always_comb begin
    if (byte_q == 10'd0) sb = FILL_C;
    else if (byte_q == 10'd1) sb = TOKEN_C;
    else if (byte_q < 10'(BLOCK_BYTES + 2)) sb = buf_rd_i;
    else sb = FILL_C;
  end
  assign store_byte_o = sb;

  // buffer ports: request index, and the next store byte on its own read port
  always_comb begin
    buf_req_o.rd_addr = in_i.buffer_index;
    buf_req_o.st_addr = BUF_AW'(byte_d - 10'd2);
    buf_req_o.wr_en = 1'b0;
    buf_req_o.wr_addr = in_i.buffer_index;
    buf_req_o.wr_data = in_i.buffer_data;
    if (step_i && in_i.opcode == OP_BUF_WR && phase_q == PH_IDLE) begin
      buf_req_o.wr_en = 1'b1;
    end
    if (step_i && adv_i && phase_q == PH_RDATA && byte_q < 10'(BLOCK_BYTES)
        && bit_q == 4'd7) begin
      buf_req_o.wr_en = 1'b1;
      buf_req_o.wr_addr = BUF_AW'(byte_q);
      buf_req_o.wr_data = {shift_q[6:0], in_i.miso};
    end
  end

  // line levels
  always_comb begin
    cs = (phase_q == PH_PREAMBLE);
    mosi = 1'b1;
    if (phase_q == PH_CMD && byte_q < 10'd48) mosi = frame[6'(10'd47 - byte_q)];
    else if (phase_q == PH_WDATA && bit_q < 4'd8) mosi = sb[3'(4'd7 - bit_q)];
  end

  // next state
  always_comb begin
    phase_d = phase_q; bit_d = bit_q; byte_d = byte_q; shift_d = shift_q;
    poll_d = poll_q; retry_d = retry_q; cmd_d = cmd_q; arg_d = arg_q;
    crc_d = crc_q; cur_d = cur_q; stat_d = stat_q;
    done = 1'b0; wr = '0; clk_p = 1'b0; rc = '0;
    if (step_i) begin
      case (opcode_e'(in_i.opcode))
        OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            clk_p = 1'b1;
            case (phase_q)
              PH_PREAMBLE: begin
                byte_d = byte_q + 10'd1;
                if (byte_d >= PREAMBLE_CLKS) begin phase_d = PH_CMD; byte_d = '0; end
              end
              PH_CMD: begin
                byte_d = byte_q + 10'd1;
                if (byte_d >= 10'd48) begin phase_d = PH_RWAIT; poll_d = '0; end
              end
              PH_RWAIT: begin
                if (!in_i.miso) begin
                  phase_d = PH_RBITS; bit_d = '0; byte_d = '0; shift_d = '0;
                end else begin
                  poll_d = poll_inc;
                  if (poll_fail) begin
                    phase_d = PH_IDLE; done = 1'b1;
                    stat_d = (cmd_q == CMD0_C) ? ST_RESET_NOT_IDLE :
                             (cmd_q == CMD1_C) ? ST_INIT_NO_ANSWER : ST_REJECTED;
                  end
                end
              end
              PH_RBITS: begin
                shift_d = {shift_q[6:0], in_i.miso};
                bit_d = bit_q + 4'd1;
                if (bit_d >= 4'd7) begin
                  rc = {1'b0, shift_d[6:0]};
                  if (cmd_q == CMD0_C) begin
                    if (rc == 8'd1) begin
                      cmd_d = CMD1_C; arg_d = '0; retry_d = '0;
                      phase_d = PH_CMD; byte_d = '0;
                    end else begin
                      phase_d = PH_IDLE; done = 1'b1; stat_d = ST_RESET_NOT_IDLE;
                    end
                  end else if (cmd_q == CMD1_C) begin
                    if (rc == 8'd0) begin
                      phase_d = PH_IDLE; done = 1'b1; stat_d = ST_OK;
                    end else begin
                      retry_d = retry_inc;
                      if (retry_inc == '0 || retry_inc >= retry_lim) begin
                        phase_d = PH_IDLE; done = 1'b1; stat_d = ST_INIT_TIMEOUT;
                      end else begin
                        phase_d = PH_CMD; byte_d = '0;
                      end
                    end
                  end else if (cmd_q == CMD17_C && rc == 8'd0) begin
                    phase_d = PH_TOKWAIT; poll_d = '0;
                  end else if (cmd_q == CMD24_C && rc == 8'd0) begin
                    phase_d = PH_WDATA; bit_d = '0; byte_d = '0; shift_d = '0;
                  end else begin
                    phase_d = PH_IDLE; done = 1'b1; stat_d = ST_REJECTED;
                  end
                end
              end
              PH_TOKWAIT: begin
                if (!in_i.miso) begin
                  phase_d = PH_RDATA; bit_d = '0; byte_d = '0; shift_d = '0;
                end else begin
                  poll_d = poll_inc;
                  if (poll_fail) begin
                    phase_d = PH_IDLE; done = 1'b1; stat_d = ST_TOKEN_TIMEOUT;
                  end
                end
              end
              PH_RDATA: begin
                bit_d = bit_q + 4'd1;
                if (byte_q < 10'(BLOCK_BYTES)) begin
                  shift_d = {shift_q[6:0], in_i.miso};
                  if (bit_d >= 4'd8) begin byte_d = byte_q + 10'd1; bit_d = '0; end
                end else begin
                  crc_d = {crc_q[14:0], in_i.miso};
                  if (bit_d >= 4'd8) begin
                    bit_d = '0; byte_d = byte_q + 10'd1;
                    if (byte_d >= 10'(BLOCK_BYTES + 2)) begin
                      cur_d = arg_q; phase_d = PH_IDLE; done = 1'b1; stat_d = ST_OK;
                    end
                  end
                end
              end
              PH_WDATA: begin
                bit_d = bit_q + 4'd1;
                if (bit_d >= 4'd8) begin
                  bit_d = '0; byte_d = byte_q + 10'd1;
                  if (byte_d >= 10'(BLOCK_BYTES + 4)) begin
                    phase_d = PH_DRWAIT; poll_d = '0;
                  end
                end
              end
              PH_DRWAIT: begin
                if (!in_i.miso) begin
                  phase_d = PH_DRBITS; bit_d = '0; byte_d = '0; shift_d = '0;
                end else begin
                  poll_d = poll_inc;
                  if (poll_fail) begin
                    phase_d = PH_IDLE; done = 1'b1; stat_d = ST_RESP_TIMEOUT;
                  end
                end
              end
              PH_DRBITS: begin
                shift_d = {shift_q[6:0], in_i.miso};
                bit_d = bit_q + 4'd1;
                if (bit_d >= 4'd4) begin phase_d = PH_NBWAIT; poll_d = '0; end
              end
              PH_NBWAIT: begin
                if (in_i.miso) begin
                  wr = shift_q[3:0]; phase_d = PH_IDLE; done = 1'b1; stat_d = ST_OK;
                end else begin
                  poll_d = poll_inc;
                  if (poll_fail) begin
                    wr = shift_q[3:0]; phase_d = PH_IDLE; done = 1'b1;
                    stat_d = ST_BUSY_TIMEOUT;
                  end
                end
              end
              default: phase_d = PH_IDLE;
            endcase
          end
        end
        OP_OPEN: begin
          if (phase_q == PH_IDLE) begin
            cmd_d = CMD0_C; arg_d = '0; phase_d = PH_PREAMBLE; byte_d = '0;
          end
        end
        OP_FETCH: begin
          if (phase_q == PH_IDLE) begin
            cmd_d = CMD17_C; arg_d = in_i.block_address; phase_d = PH_CMD; byte_d = '0;
          end
        end
        OP_STORE, OP_FLUSH: begin
          if (phase_q == PH_IDLE) begin
            cmd_d = CMD24_C;
            arg_d = (in_i.opcode == OP_STORE) ? in_i.block_address : cur_q;
            phase_d = PH_CMD; byte_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_d.chip_select_level = cs;
    res_d.mosi_level = mosi;
    res_d.clock_pulse = clk_p;
    res_d.busy_res = (phase_d != PH_IDLE);
    res_d.done_res = done;
    res_d.status = stat_d;
    res_d.write_response = wr;
    res_d.read_data = '0;
    res_d.crc_value = crc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; bit_q <= '0; byte_q <= '0; shift_q <= '0;
      poll_q <= '0; retry_q <= '0; cmd_q <= '0; arg_q <= '0;
      crc_q <= 16'hffff; cur_q <= '0; stat_q <= ST_OK;
      poll_lim_q <= 16'hffff; retry_lim_q <= 16'hffff;
    end else begin
      phase_q <= phase_d; bit_q <= bit_d; byte_q <= byte_d; shift_q <= shift_d;
      poll_q <= poll_d; retry_q <= retry_d; cmd_q <= cmd_d; arg_q <= arg_d;
      crc_q <= crc_d; cur_q <= cur_d; stat_q <= stat_d;
      if (cfg_we_i && cfg_idx_i == CFG_BUSY_POLL) poll_lim_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_INIT_RETRY) retry_lim_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) res_o <= res_d;
  end

  logic unused;
  assign unused = ^cur_blk_d;

endmodule

// ----- sv/sd_card_spi_block_host.sv -----
// top level: sd card spi mode host with block buffer
// channel | valid         | stall         | payload
// in      | in_valid_i    | in_stall_o    | in_item_i  (sdh_in_t)
// out     | out_valid_o   | out_stall_i   | out_item_o (sdh_out_t)
// one item per cycle while the input is not stalled; each item's result appears the cycle after it is taken
// the store byte and buffer read data come from the registered buffer read ports
// reset clears the control state and loads the crc and limit registers with all ones
// the input stalls only while a result waits and the output is stalled
`timescale 1ns / 1ps
module sd_card_spi_block_host import sdh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sdh_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sdh_out_t    out_item_o
);

  sdh_buf_req_t buf_req;
  logic [7:0]   buf_rd, buf_st, store_byte;
  logic         step, valid_q, rd_q;
  sdh_out_t     res;

  assign in_stall_o = valid_q && out_stall_i;
  assign step = in_valid_i && !in_stall_o;

  sdh_seq u_seq (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .step_i(step), .in_i(in_item_i), .adv_i(1'b1), .buf_rd_i(buf_st),
    .buf_req_o(buf_req), .store_byte_o(store_byte), .res_o(res)
  );

  sdh_buffer u_buf (.clk_i, .req_i(buf_req), .rd_data_o(buf_rd), .st_data_o(buf_st));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      if (step) valid_q <= 1'b1;
      else if (!out_stall_i) valid_q <= 1'b0;
      if (step) rd_q <= (in_item_i.opcode == OP_BUF_RD);
    end
  end

  logic [7:0] rd_hold_q;
  logic       first_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) first_q <= 1'b0;
    else first_q <= step;
  end
  always_ff @(posedge clk_i) begin
    if (first_q) rd_hold_q <= buf_rd;
  end

  always_comb begin
    out_item_o = res;
    out_item_o.read_data = rd_q ? (first_q ? buf_rd : rd_hold_q) : 8'h00;
  end
  assign out_valid_o = valid_q;

  logic unused;
  assign unused = ^store_byte;

endmodule

// ----- sv/sdh_checker.sv -----
// port checker for the sd card spi block host, bound to the top level
`timescale 1ns / 1ps
module sdh_checker import sdh_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sdh_out_t out_item_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o)) else $error("held");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o) else $error("no result");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res) else $error("done busy");
  a_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.chip_select_level |-> out_item_o.mosi_level) else $error("cs");

endmodule

bind sd_card_spi_block_host sdh_checker u_chk (.*);

// ----- bench/tb.sv -----
// testbench for the sd card spi block host: predicts every result and checks it as a whole
`timescale 1ns / 1ps
module tb;
  import sdh_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sdh_in_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sdh_out_t out_item_o;

  sd_card_spi_block_host dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // host model state
  logic [15:0] poll_lim, retry_lim;
  phase_e ph;
  int unsigned bit_cnt, byte_cnt;
  logic [7:0] shreg;
  logic [15:0] poll_cnt, retry_cnt;
  logic [47:0] frame;
  logic [7:0] blk [BLOCK_BYTES];
  bit written [BLOCK_BYTES];
  logic [15:0] crc_reg;
  logic [31:0] cur_blk;
  logic [2:0] last_st;

  sdh_out_t expected_q[$];
  int errors = 0;
  bit hold_rx = 1'b0;
  int rx_wait = 0;

  // card side behavior for miso generation
  int card_mode = 0;

  function automatic logic [15:0] lim_of(logic [15:0] v);
    return v == 0 ? 16'd1 : v;
  endfunction

  function automatic logic [7:0] store_byte_at(int unsigned i);
    if (i == 0) return FILL_C;
    if (i == 1) return TOKEN_C;
    if (i < BLOCK_BYTES + 2) return blk[i - 2];
    return FILL_C;
  endfunction

  function automatic void host_finish(logic [2:0] st, ref logic done);
    ph = PH_IDLE;
    last_st = st;
    done = 1'b1;
  endfunction

  function automatic bit poll_over();
    poll_cnt = poll_cnt + 16'd1;
    return poll_cnt == 0 || poll_cnt >= lim_of(poll_lim);
  endfunction

  function automatic void begin_bits(phase_e p);
    ph = p;
    bit_cnt = 0;
    byte_cnt = 0;
    shreg = '0;
  endfunction

  function automatic void take_answer(logic [6:0] rc, ref logic done);
    logic [7:0] c;
    c = frame[47:40];
    if (c == CMD0_C) begin
      if (rc == 1) begin
        frame = {CMD1_C, 32'd0, 8'd0};
        retry_cnt = 0;
        ph = PH_CMD;
        byte_cnt = 0;
      end else host_finish(ST_RESET_NOT_IDLE, done);
    end else if (c == CMD1_C) begin
      if (rc == 0) host_finish(ST_OK, done);
      else begin
        retry_cnt = retry_cnt + 16'd1;
        if (retry_cnt == 0 || retry_cnt >= lim_of(retry_lim)) host_finish(ST_INIT_TIMEOUT, done);
        else begin
          ph = PH_CMD;
          byte_cnt = 0;
        end
      end
    end else if (c == CMD17_C && rc == 0) begin
      ph = PH_TOKWAIT;
      poll_cnt = 0;
    end else if (c == CMD24_C && rc == 0) begin_bits(PH_WDATA);
    else host_finish(ST_REJECTED, done);
  endfunction

  function automatic void serial_step(logic m, ref logic done, ref logic [3:0] wr);
    logic [7:0] c;
    case (ph)
      PH_PREAMBLE: begin
        byte_cnt++;
        if (byte_cnt >= PREAMBLE_CLKS) begin
          ph = PH_CMD;
          byte_cnt = 0;
        end
      end
      PH_CMD: begin
        byte_cnt++;
        if (byte_cnt >= 48) begin
          ph = PH_RWAIT;
          poll_cnt = 0;
        end
      end
      PH_RWAIT: begin
        if (!m) begin_bits(PH_RBITS);
        else if (poll_over()) begin
          c = frame[47:40];
          host_finish(c == CMD0_C ? ST_RESET_NOT_IDLE :
                      (c == CMD1_C ? ST_INIT_NO_ANSWER : ST_REJECTED), done);
        end
      end
      PH_RBITS: begin
        shreg = {shreg[6:0], m};
        bit_cnt++;
        if (bit_cnt >= 7) take_answer(shreg[6:0], done);
      end
      PH_TOKWAIT: begin
        if (!m) begin_bits(PH_RDATA);
        else if (poll_over()) host_finish(ST_TOKEN_TIMEOUT, done);
      end
      PH_RDATA: begin
        if (byte_cnt < BLOCK_BYTES) begin
          shreg = {shreg[6:0], m};
          bit_cnt++;
          if (bit_cnt >= 8) begin
            blk[byte_cnt] = shreg;
            written[byte_cnt] = 1'b1;
            byte_cnt++;
            bit_cnt = 0;
          end
        end else begin
          crc_reg = {crc_reg[14:0], m};
          bit_cnt++;
          if (bit_cnt >= 8) begin
            bit_cnt = 0;
            byte_cnt++;
            if (byte_cnt >= BLOCK_BYTES + 2) begin
              cur_blk = frame[39:8];
              host_finish(ST_OK, done);
            end
          end
        end
      end
      PH_WDATA: begin
        bit_cnt++;
        if (bit_cnt >= 8) begin
          bit_cnt = 0;
          byte_cnt++;
          if (byte_cnt >= BLOCK_BYTES + 4) begin
            ph = PH_DRWAIT;
            poll_cnt = 0;
          end
        end
      end
      PH_DRWAIT: begin
        if (!m) begin_bits(PH_DRBITS);
        else if (poll_over()) host_finish(ST_RESP_TIMEOUT, done);
      end
      PH_DRBITS: begin
        shreg = {shreg[6:0], m};
        bit_cnt++;
        if (bit_cnt >= 4) begin
          ph = PH_NBWAIT;
          poll_cnt = 0;
        end
      end
      PH_NBWAIT: begin
        if (m) begin
          wr = shreg[3:0];
          host_finish(ST_OK, done);
        end else if (poll_over()) begin
          wr = shreg[3:0];
          host_finish(ST_BUSY_TIMEOUT, done);
        end
      end
      default: ph = PH_IDLE;
    endcase
  endfunction

  function automatic sdh_out_t host_predict(sdh_in_t it);
    sdh_out_t r;
    logic done;
    logic [3:0] wr;
    logic [7:0] sbyte;
    bit idle;
    r = '0;
    done = 1'b0;
    wr = '0;
    idle = (ph == PH_IDLE);
    r.mosi_level = 1'b1;
    if (ph == PH_PREAMBLE) r.chip_select_level = 1'b1;
    if (ph == PH_CMD && byte_cnt < 48) r.mosi_level = frame[47 - byte_cnt];
    else if (ph == PH_WDATA && bit_cnt < 8) begin
      sbyte = store_byte_at(byte_cnt);
      r.mosi_level = sbyte[7 - bit_cnt];
    end
    case (opcode_e'(it.opcode))
      OP_TICK: if (!idle) begin
        r.clock_pulse = 1'b1;
        serial_step(it.miso, done, wr);
      end
      OP_OPEN: if (idle) begin
        frame = {CMD0_C, 32'd0, CRC0_C};
        ph = PH_PREAMBLE;
        byte_cnt = 0;
      end
      OP_FETCH: if (idle) begin
        frame = {CMD17_C, it.block_address, 8'd0};
        ph = PH_CMD;
        byte_cnt = 0;
      end
      OP_STORE, OP_FLUSH: if (idle) begin
        frame = {CMD24_C, it.opcode == OP_STORE ? it.block_address : cur_blk, 8'd0};
        ph = PH_CMD;
        byte_cnt = 0;
      end
      OP_BUF_WR: if (idle) begin
        blk[it.buffer_index] = it.buffer_data;
        written[it.buffer_index] = 1'b1;
      end
      OP_BUF_RD: r.read_data = blk[it.buffer_index];
      default: ;
    endcase
    r.busy_res = ph != PH_IDLE;
    r.done_res = done;
    r.status = last_st;
    r.write_response = wr;
    r.crc_value = crc_reg;
    return r;
  endfunction

  task automatic send_item(sdh_in_t it, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? int'($urandom_range(0, 9)) : 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (it.opcode == OP_BUF_RD && !written[it.buffer_index]) it.opcode = OP_TICK;
    in_item_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(host_predict(it));
  endtask

  // miso source mimicking a cooperating card, with noise by mode
  function automatic logic card_miso();
    if (card_mode == 1) return 1'($urandom_range(0, 1));
    case (ph)
      PH_RWAIT, PH_TOKWAIT, PH_DRWAIT: return $urandom_range(0, 3) != 0;
      PH_RBITS: begin
        if (frame[47:40] == CMD0_C) return bit_cnt == 6;
        if (frame[47:40] == CMD1_C) return $urandom_range(0, 3) == 0 && bit_cnt == 6;
        return card_mode == 2 ? 1'($urandom_range(0, 1)) : 1'b0;
      end
      PH_NBWAIT: return $urandom_range(0, 2) == 0;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic sdh_in_t rand_item(opcode_e op);
    sdh_in_t it;
    it.opcode = op;
    it.block_address = $urandom;
    it.buffer_index = 9'($urandom_range(0, 511));
    it.buffer_data = 8'($urandom_range(0, 255));
    it.miso = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic tick(int n);
    sdh_in_t it;
    repeat (n) begin
      it = rand_item(OP_TICK);
      it.miso = card_miso();
      send_item(it);
    end
  endtask

  task automatic run_op(opcode_e op, int max_ticks);
    int n;
    send_item(rand_item(op));
    n = 0;
    while (ph != PH_IDLE && n < max_ticks) begin
      tick(1);
      n++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] v);
    wait_drained();
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BUSY_POLL) poll_lim = v;
    else retry_lim = v;
  endtask

  task automatic test_directed();
    sdh_in_t it;
    send_item(rand_item(OP_NONE));
    send_item(rand_item(OP_TICK));
    it = rand_item(OP_BUF_WR);
    it.buffer_index = 0;
    it.buffer_data = 8'hff;
    send_item(it);
    it.buffer_index = 511;
    it.buffer_data = 8'h00;
    send_item(it);
    it.opcode = OP_BUF_RD;
    send_item(it);
    it.buffer_index = 0;
    send_item(it);
    card_mode = 0;
    write_reg(CFG_BUSY_POLL, 16'd20);
    write_reg(CFG_INIT_RETRY, 16'd3);
    run_op(OP_OPEN, 400);
    write_reg(CFG_INIT_RETRY, 16'd0);
    run_op(OP_OPEN, 300);
    card_mode = 2;
    it = rand_item(OP_FETCH);
    it.block_address = 32'hffffffff;
    send_item(it);
    send_item(rand_item(OP_OPEN));
    send_item(rand_item(OP_BUF_WR));
    tick(60);
    run_op(OP_FLUSH, 80);
    it = rand_item(OP_STORE);
    it.block_address = 32'h0;
    send_item(it);
    tick(60);
  endtask

  task automatic test_timeouts();
    write_reg(CFG_BUSY_POLL, 16'd1);
    card_mode = 1;
    run_op(OP_OPEN, 200);
    repeat (2) run_op(OP_FETCH, 100);
    write_reg(CFG_BUSY_POLL, 16'd0);
    repeat (2) run_op(OP_STORE, 100);
    card_mode = 2;
    write_reg(CFG_BUSY_POLL, 16'd3);
    repeat (2) run_op(OP_STORE, 80);
  endtask

  task automatic test_random();
    int k;
    opcode_e op;
    write_reg(CFG_BUSY_POLL, 16'hffff);
    write_reg(CFG_INIT_RETRY, 16'hffff);
    for (k = 0; k < 10; k++) begin
      card_mode = $urandom_range(0, 5) == 0 ? 2 : 0;
      op = opcode_e'($urandom_range(0, 7));
      if (op == OP_TICK) tick($urandom_range(1, 20));
      else run_op(op, 30);
    end
    write_reg(CFG_BUSY_POLL, 16'd5);
    write_reg(CFG_INIT_RETRY, 16'd2);
    for (k = 0; k < 8; k++) begin
      card_mode = $urandom_range(0, 2);
      run_op(opcode_e'($urandom_range(1, 6)), 20);
    end
  endtask

  task automatic test_backpressure();
    sdh_in_t it;
    fork
      begin
        hold_rx = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (30) begin
        it = rand_item(OP_BUF_RD);
        send_item(it, 1);
      end
    join
    wait_drained();
    tick(3);
  endtask

  // receiver: random waits per item and result checking
  initial begin
    sdh_out_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $time, out_item_o);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_item_o !== exp_r) begin
            errors++;
            $display("%0t mismatch expected %h actual %h", $time, exp_r, out_item_o);
          end
        end
        rx_wait = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 9)) : 0;
      end
      out_stall_i <= hold_rx || (rx_wait != 0);
      if (rx_wait != 0) rx_wait--;
    end
  end

  initial begin
    poll_lim = 16'hffff;
    retry_lim = 16'hffff;
    ph = PH_IDLE;
    bit_cnt = 0;
    byte_cnt = 0;
    shreg = '0;
    poll_cnt = '0;
    retry_cnt = '0;
    frame = '0;
    crc_reg = 16'hffff;
    cur_blk = '0;
    last_st = '0;
    foreach (written[i]) written[i] = 1'b0;
    foreach (blk[i]) blk[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_timeouts();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[sd_card_spi_block_host] OK");
    end else begin
      $display("[sd_card_spi_block_host] ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("[sd_card_spi_block_host] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
sv/sdh_pkg.sv
sv/sdh_buffer.sv
sv/sdh_seq.sv
sv/sd_card_spi_block_host.sv
sv/sdh_checker.sv
bench/tb.sv
